// ===== rtl/ctt_pkg.sv =====
// Shared types, character codes and helpers for the config text tokenizer.
// Used by every module of the block but ctt_ram; depends on nothing.
package ctt_pkg;

  localparam int HOLD_DEPTH = 16;
  localparam int HOLD_CAP   = (HOLD_DEPTH < 16) ? HOLD_DEPTH : 16;
  localparam int HOLD_AW    = (HOLD_CAP > 1) ? $clog2(HOLD_CAP) : 1;
  localparam int HOLD_CW    = $clog2(HOLD_CAP + 1);

  localparam logic [15:0] LINE_MAX = 16'hFFFF;
  localparam logic [11:0] COL_MAX  = 12'hFFF;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [2:0] {
    KIND_NAME   = 3'd0,
    KIND_VALUE  = 3'd1,
    KIND_LBRACE = 3'd2,
    KIND_RBRACE = 3'd3,
    KIND_STRING = 3'd4,
    KIND_EOF    = 3'd5
  } tok_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_VAL_END   = 3'd1,
    ERR_VAL_STOP  = 3'd2,
    ERR_OPEN_STR  = 3'd3,
    ERR_BAD_CHAR  = 3'd4,
    ERR_SPACE_OVF = 3'd5
  } err_code_e;

  typedef enum logic [2:0] {
    M_TOP   = 3'd0,
    M_NAME  = 3'd1,
    M_VSKIP = 3'd2,
    M_VBODY = 3'd3,
    M_STR   = 3'd4,
    M_CMNT  = 3'd5,
    M_EOF   = 3'd6,
    M_HALT  = 3'd7
  } scan_mode_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_FLUSH = 2'd1,
    BK_EMIT  = 2'd2
  } back_state_e;

  typedef struct packed {
    logic [7:0] ch_in;
    logic       at_end;
  } tok_in_t;

  typedef struct packed {
    logic [2:0]  tok_kind;
    logic [7:0]  out_char;
    logic        char_valid;
    logic        token_done;
    logic [15:0] line_no;
    logic [11:0] col_no;
    logic [2:0]  error_code;
    logic        last;
  } tok_out_t;

  // One result without position
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic       valid;
    logic       done;
    logic [2:0] err;
  } res_t;

  // Work for the back end caused by one word
  typedef struct packed {
    res_t [2:0]          res;
    logic [1:0]          n_res;
    logic                push;
    logic                flush;
    logic [HOLD_CW-1:0]  aux;
    logic [7:0]          ch;
    logic [15:0]         line;
    logic [11:0]         col;
  } cmd_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [7:0] ch, logic valid,
                                  logic done, logic [2:0] err);
    res_t r;
    r.kind  = kind;
    r.ch    = valid ? ch : 8'h00;
    r.valid = valid;
    r.done  = done;
    r.err   = err;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c inside {CH_SPACE, [8'd9:8'd13]};
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_USCORE};
  endfunction

  function automatic logic is_stop(logic [7:0] c);
    return c inside {CH_LBRACE, CH_RBRACE, CH_EQ, CH_SEMI, CH_NL};
  endfunction

  function automatic logic is_quote(logic [7:0] c);
    return c inside {CH_DQUOTE, CH_SQUOTE};
  endfunction

endpackage

// ===== rtl/ctt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ctt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ctt_front.sv =====
// Front end: accepts words, runs the scan state machine and line/column tracking,
// and turns each word that yields results or a held space into one back-end command. Depends on ctt_pkg.
module ctt_front import ctt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  tok_in_t in_data_i,
  input  logic    q_full_i,
  output logic    cmd_push_o,
  output cmd_t    cmd_o
);

  scan_mode_e        mode_q, mode_d;
  logic [7:0]        quote_q, quote_d;
  logic [15:0]       line_q, line_d;
  logic [11:0]       col_q, col_d;
  logic [HOLD_CW-1:0] held_q, held_d;
  logic              vstart_q, vstart_d;
  logic [2:0]        err_q, err_d;

  cmd_t       cmd;
  logic [7:0] c;
  logic       fin;
  logic       again;
  logic [1:0] n;
  logic [2:0] str_kind;
  logic       accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    mode_d   = mode_q;
    quote_d  = quote_q;
    line_d   = line_q;
    col_d    = col_q;
    held_d   = held_q;
    vstart_d = vstart_q;
    err_d    = err_q;
    cmd      = '0;
    n        = 2'd0;
    again    = 1'b1;
    str_kind = KIND_STRING;
    c        = in_data_i.ch_in;
    fin      = in_data_i.at_end;
    cmd.line = line_q;
    cmd.col  = col_q;

    if (mode_q == M_HALT) begin
      cmd.res[0] = mk_res(KIND_NAME, 8'h00, 1'b0, 1'b0, err_q);
      n = 2'd1;
    end else if (mode_q == M_EOF) begin
      cmd.res[0] = mk_res(KIND_EOF, 8'h00, 1'b0, 1'b1, ERR_NONE);
      n = 2'd1;
    end else begin
      // A character that ends a name, value or comment gets a second pass at top level
      for (int p = 0; p < 2; p++) begin
        if (again) begin
          again = 1'b0;
          case (mode_d)
            M_TOP: begin
              if (fin) begin
                cmd.res[n] = mk_res(KIND_EOF, 8'h00, 1'b0, 1'b1, ERR_NONE);
                n = n + 2'd1;
                mode_d = M_EOF;
              end else if (c == CH_LBRACE || c == CH_RBRACE) begin
                cmd.res[n] = mk_res((c == CH_LBRACE) ? KIND_LBRACE : KIND_RBRACE,
                                    c, 1'b1, 1'b0, ERR_NONE);
                n = n + 2'd1;
                cmd.res[n] = mk_res((c == CH_LBRACE) ? KIND_LBRACE : KIND_RBRACE,
                                    8'h00, 1'b0, 1'b1, ERR_NONE);
                n = n + 2'd1;
              end else if (c == CH_EQ) begin
                mode_d   = M_VSKIP;
                vstart_d = 1'b0;
              end else if (c == CH_SEMI) begin
                mode_d = M_CMNT;
              end else if (is_quote(c)) begin
                quote_d  = c;
                vstart_d = 1'b0;
                mode_d   = M_STR;
              end else if (is_space(c)) begin
                mode_d = M_TOP;
              end else if (is_letter(c)) begin
                cmd.res[n] = mk_res(KIND_NAME, c, 1'b1, 1'b0, ERR_NONE);
                n = n + 2'd1;
                mode_d = M_NAME;
              end else begin
                cmd.res[n] = mk_res(KIND_NAME, 8'h00, 1'b0, 1'b0, ERR_BAD_CHAR);
                n = n + 2'd1;
                err_d  = ERR_BAD_CHAR;
                mode_d = M_HALT;
              end
            end
            M_NAME: begin
              if (!fin && is_letter(c)) begin
                cmd.res[n] = mk_res(KIND_NAME, c, 1'b1, 1'b0, ERR_NONE);
                n = n + 2'd1;
              end else begin
                cmd.res[n] = mk_res(KIND_NAME, 8'h00, 1'b0, 1'b1, ERR_NONE);
                n = n + 2'd1;
                mode_d = M_TOP;
                again  = 1'b1;
              end
            end
            M_VSKIP: begin
              if (fin || (!is_space(c) && is_stop(c))) begin
                cmd.res[n] = mk_res(KIND_NAME, 8'h00, 1'b0, 1'b0,
                                    fin ? ERR_VAL_END : ERR_VAL_STOP);
                n = n + 2'd1;
                err_d  = fin ? ERR_VAL_END : ERR_VAL_STOP;
                mode_d = M_HALT;
              end else if (is_space(c)) begin
                mode_d = M_VSKIP;
              end else if (is_quote(c)) begin
                quote_d  = c;
                vstart_d = 1'b1;
                mode_d   = M_STR;
              end else begin
                cmd.res[n] = mk_res(KIND_VALUE, c, 1'b1, 1'b0, ERR_NONE);
                n = n + 2'd1;
                held_d = '0;
                mode_d = M_VBODY;
              end
            end
            M_VBODY: begin
              if (fin || is_stop(c)) begin
                held_d = '0;
                cmd.res[n] = mk_res(KIND_VALUE, 8'h00, 1'b0, 1'b1, ERR_NONE);
                n = n + 2'd1;
                mode_d = M_TOP;
                again  = 1'b1;
              end else if (is_space(c)) begin
                if (held_d < HOLD_CW'(HOLD_CAP)) begin
                  cmd.push = 1'b1;
                  cmd.aux  = held_d;
                  cmd.ch   = c;
                  held_d   = held_d + HOLD_CW'(1);
                end else begin
                  cmd.res[n] = mk_res(KIND_NAME, 8'h00, 1'b0, 1'b0, ERR_SPACE_OVF);
                  n = n + 2'd1;
                  err_d  = ERR_SPACE_OVF;
                  mode_d = M_HALT;
                end
              end else begin
                // replay the held spaces ahead of this character
                cmd.flush = 1'b1;
                cmd.aux   = held_d;
                held_d    = '0;
                cmd.res[n] = mk_res(KIND_VALUE, c, 1'b1, 1'b0, ERR_NONE);
                n = n + 2'd1;
              end
            end
            M_STR: begin
              str_kind = vstart_d ? KIND_VALUE : KIND_STRING;
              if (fin) begin
                cmd.res[n] = mk_res(KIND_NAME, 8'h00, 1'b0, 1'b0, ERR_OPEN_STR);
                n = n + 2'd1;
                err_d  = ERR_OPEN_STR;
                mode_d = M_HALT;
              end else if (c == quote_d) begin
                cmd.res[n] = mk_res(str_kind, 8'h00, 1'b0, 1'b1, ERR_NONE);
                n = n + 2'd1;
                mode_d   = M_TOP;
                vstart_d = 1'b0;
              end else begin
                cmd.res[n] = mk_res(str_kind, c, 1'b1, 1'b0, ERR_NONE);
                n = n + 2'd1;
              end
            end
            M_CMNT: begin
              if (fin || c == CH_NL) begin
                mode_d = M_TOP;
                again  = 1'b1;
              end
            end
            default: begin
              mode_d = mode_d;
            end
          endcase
        end
      end

      if (!fin && mode_d != M_HALT) begin
        if (c == CH_NL) begin
          if (line_q != LINE_MAX) begin
            line_d = line_q + 16'd1;
          end
          col_d = 12'd1;
        end else if (col_q != COL_MAX) begin
          col_d = col_q + 12'd1;
        end
      end
    end

    cmd.n_res = n;
  end

  assign cmd_o      = cmd;
  assign cmd_push_o = accept && ((n != 2'd0) || cmd.push);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_TOP;
      quote_q  <= 8'h00;
      line_q   <= 16'd1;
      col_q    <= 12'd1;
      held_q   <= '0;
      vstart_q <= 1'b0;
      err_q    <= ERR_NONE;
    end else if (accept) begin
      mode_q   <= mode_d;
      quote_q  <= quote_d;
      line_q   <= line_d;
      col_q    <= col_d;
      held_q   <= held_d;
      vstart_q <= vstart_d;
      err_q    <= err_d;
    end
  end

endmodule

// ===== rtl/ctt_fifo.sv =====
// Two-entry command queue between front and back end.
// Depends on ctt_pkg for the command type.
module ctt_fifo import ctt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t data_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign cnt_d   = cnt_q + {1'b0, push_i} - {1'b0, pop_i};

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/ctt_back.sv =====
// Back end: pops commands, keeps the held-space store, replays held spaces and
// drives the output word register. Depends on ctt_pkg and ctt_ram.
module ctt_back import ctt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  cmd_t     cmd_i,
  output logic     cmd_pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tok_out_t out_data_o
);

  back_state_e        state_q, state_d;
  cmd_t               cur_q, cur_d;
  logic [HOLD_CW-1:0] fidx_q, fidx_d, fidx_nxt;
  logic [1:0]         ridx_q, ridx_d;
  logic               out_valid_q, out_valid_d;
  tok_out_t           out_q, out_d;

  logic               out_free;
  logic               take;
  logic               res_last;
  res_t               res;
  logic               ram_we;
  logic               ram_re;
  logic [HOLD_AW-1:0] ram_raddr;
  logic [7:0]         ram_rdata;

  ctt_ram #(
    .WIDTH (8),
    .DEPTH (HOLD_CAP)
  ) u_hold_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_i.aux[HOLD_AW-1:0]),
    .wdata_i (cmd_i.ch),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign fidx_nxt = fidx_q + HOLD_CW'(1);
  assign res      = cur_q.res[ridx_q];
  assign res_last = (ridx_q == (cur_q.n_res - 2'd1));

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    fidx_d      = fidx_q;
    ridx_d      = ridx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    take        = 1'b0;
    out_free    = !out_valid_q || out_ready_i;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      BK_IDLE: begin
        take = cmd_valid_i;
      end
      BK_FLUSH: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.tok_kind   = KIND_VALUE;
          out_d.out_char   = ram_rdata;
          out_d.char_valid = 1'b1;
          out_d.token_done = 1'b0;
          out_d.line_no    = cur_q.line;
          out_d.col_no     = cur_q.col;
          out_d.error_code = ERR_NONE;
          out_d.last       = 1'b0;
          if (fidx_nxt == cur_q.aux) begin
            ridx_d  = 2'd0;
            state_d = BK_EMIT;
          end else begin
            // prefetch the next held space
            ram_re    = 1'b1;
            ram_raddr = fidx_nxt[HOLD_AW-1:0];
            fidx_d    = fidx_nxt;
          end
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.tok_kind   = res.kind;
          out_d.out_char   = res.ch;
          out_d.char_valid = res.valid;
          out_d.token_done = res.done;
          out_d.line_no    = cur_q.line;
          out_d.col_no     = cur_q.col;
          out_d.error_code = res.err;
          out_d.last       = res_last;
          if (res_last) begin
            state_d = BK_IDLE;
            take    = cmd_valid_i;
          end else begin
            ridx_d = ridx_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    if (take) begin
      cmd_pop_o = 1'b1;
      cur_d     = cmd_i;
      if (cmd_i.push) begin
        ram_we  = 1'b1;
        state_d = BK_IDLE;
      end else if (cmd_i.flush && (cmd_i.aux != '0)) begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        fidx_d    = '0;
        state_d   = BK_FLUSH;
      end else begin
        ridx_d  = 2'd0;
        state_d = BK_EMIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      fidx_q      <= '0;
      ridx_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fidx_q      <= fidx_d;
      ridx_q      <= ridx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/config_text_tokenizer_core.sv =====
// Config text tokenizer: one text byte per input word, 0 to 17 result words out.
// A word passes the command queue, the command register and the output word register;
// held spaces replay ahead of the character, the first RAM read overlaps command pickup.
// Input: one word per cycle while the 2-entry command queue has room. Output: one result
// word per cycle while out_ready_i is high; a word that only stores a space yields none.
// Reset (async, active low) returns to top level, line 1, col 1.
module config_text_tokenizer_core import ctt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tok_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tok_out_t out_data_o
);

  logic cmd_push;
  cmd_t cmd_in;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t q_data;

  ctt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  ctt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_data)
  );

  ctt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_data),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/ctt_checker.sv =====
// Port-level checks for the config text tokenizer, bound to the top level.
// Depends on ctt_pkg.
module ctt_checker import ctt_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input tok_out_t out_data_i
);

  logic [2:0] err_seen_q;
  logic       eof_seen_q;

  // Track the latest error and whether end of file has been seen on the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= ERR_NONE;
      eof_seen_q <= 1'b0;
    end else if (out_valid_i && out_ready_i) begin
      if (out_data_i.error_code != ERR_NONE) begin
        err_seen_q <= out_data_i.error_code;
      end
      if (out_data_i.tok_kind == KIND_EOF && out_data_i.token_done) begin
        eof_seen_q <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output word changed while stalled");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.error_code != ERR_NONE |->
      !out_data_i.char_valid && !out_data_i.token_done && out_data_i.out_char == 8'h00
      && out_data_i.tok_kind == KIND_NAME && out_data_i.last)
    else $error("malformed error result");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && err_seen_q != ERR_NONE |-> out_data_i.error_code == err_seen_q)
    else $error("result after error does not repeat the error");

  a_eof_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && eof_seen_q |->
      out_data_i.tok_kind == KIND_EOF && out_data_i.token_done && out_data_i.last
      && out_data_i.error_code == ERR_NONE)
    else $error("result after end of file is not an end-of-file marker");

  a_done_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.token_done |->
      !out_data_i.char_valid && out_data_i.out_char == 8'h00)
    else $error("token end marker carries a character");

endmodule

bind config_text_tokenizer_core ctt_checker u_ctt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
